// File: hdl/fpc_pkg.sv
// Shared types and constants of the frame parser with CRC16 check.
`default_nettype none

package fpc_pkg;

   // Largest payload the parser accepts, whatever the limit register says.
   localparam int unsigned PAYLOAD_DEPTH = 256;

   localparam int unsigned CSR_INDEX_WIDTH = 8;
   localparam int unsigned CSR_DATA_WIDTH  = 9;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SOF_FIRST     = 8'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SOF_SECOND    = 8'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FRAME_VERSION = 8'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PAYLOAD_LIMIT = 8'd3;

   // Configuration reset values.
   localparam logic [7:0] SOF_FIRST_RESET     = 8'hAA;
   localparam logic [7:0] SOF_SECOND_RESET    = 8'h55;
   localparam logic [7:0] FRAME_VERSION_RESET = 8'h01;
   localparam logic [8:0] PAYLOAD_LIMIT_RESET = 9'd256;

   // CRC16-CCITT-FALSE.
   localparam logic [15:0] CRC_POLY = 16'h1021;
   localparam logic [15:0] CRC_INIT = 16'hFFFF;

   // Result status codes.
   localparam logic [1:0] STATUS_NONE         = 2'd0;
   localparam logic [1:0] STATUS_FRAME_READY  = 2'd1;
   localparam logic [1:0] STATUS_CRC_ERROR    = 2'd2;
   localparam logic [1:0] STATUS_FORMAT_ERROR = 2'd3;

   typedef enum logic [3:0] {
      ST_SOF0 = 4'd0,
      ST_SOF1 = 4'd1,
      ST_VER  = 4'd2,
      ST_TYPE = 4'd3,
      ST_SEQL = 4'd4,
      ST_SEQH = 4'd5,
      ST_LENL = 4'd6,
      ST_LENH = 4'd7,
      ST_DATA = 4'd8,
      ST_CRCL = 4'd9,
      ST_CRCH = 4'd10
   } parse_state_type;

endpackage

`default_nettype wire

// File: hdl/fpc_crc_step.sv
// Byte-wide CRC16-CCITT-FALSE update: MSB first, no reflection.
`default_nettype none

module fpc_crc_step (
   input  wire logic [15:0] crc_cur,
   input  wire logic [7:0]  data_byte,
   output logic      [15:0] crc_next
);
   import fpc_pkg::*;

   always_comb begin
      logic [15:0] acc;
      acc = crc_cur ^ {data_byte, 8'h00};
      for (int k = 0; k < 8; k++) begin
         if (acc[15]) begin
            acc = {acc[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            acc = {acc[14:0], 1'b0};
         end
      end
      crc_next = acc;
   end

endmodule

`default_nettype wire

// File: hdl/frame_parser_crc16.sv
// Top level of the byte-serial frame parser with CRC16-CCITT-FALSE check.
//
// The parser takes one received byte per request transaction and returns
// exactly one response transaction for every byte, in order. A frame is two
// start bytes, a version byte, a type byte, a little-endian sequence number,
// a little-endian payload length, the payload and a little-endian CRC over
// version through payload. The parse state, the running CRC and the next-state
// decode form one short path into the state registers and a response register,
// so one byte per cycle is sustained while the consumer takes the responses.
// The response register decouples the two sides: req_ready is high whenever the
// response register is empty or its content is being taken in the same cycle,
// so a response appears in the cycle after its byte is taken; throughput is
// one byte per cycle while rsp_ready stays high. Payload bytes are not stored;
// they are streamed out with payload_valid set and their index. The held type,
// sequence and length fields show the state left by the byte being reported
// and keep their values until a later frame overwrites them. A bad version or
// an over-limit length ends the frame with a format error, and that byte may
// start the next frame if it equals the first start byte. Configuration
// registers are written through the csr port, which is always ready; writes
// to an unknown index are ignored. Configuration should only be changed while
// no byte is in flight.
`default_nettype none

module frame_parser_crc16 (
   input  wire logic                                clock,
   input  wire logic                                reset,

   // Byte input
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [7:0]                          req_in_byte,

   // Per-byte result
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic      [1:0]                          rsp_status,
   output logic      [7:0]                          rsp_frame_kind,
   output logic      [15:0]                         rsp_sequence_res,
   output logic      [15:0]                         rsp_body_length,
   output logic                                     rsp_payload_valid,
   output logic      [7:0]                          rsp_payload_byte,
   output logic      [7:0]                          rsp_body_index,

   // Configuration writes
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [fpc_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [fpc_pkg::CSR_DATA_WIDTH-1:0]  csr_data
);
   import fpc_pkg::*;

   // Limit width: enough bits to hold PAYLOAD_DEPTH itself.
   localparam int unsigned LIMIT_WIDTH = $clog2(PAYLOAD_DEPTH + 1);

   // Configuration registers
   logic [7:0] sof_first_ff;
   logic [7:0] sof_second_ff;
   logic [7:0] frame_version_ff;
   logic [8:0] payload_limit_ff;

   // Parser state
   parse_state_type state_ff, state_in;
   logic [15:0]     crc_running_ff, crc_running_in;
   logic [7:0]      crc_low_ff, crc_low_in;
   logic [8:0]      payload_count_ff, payload_count_in;
   logic [7:0]      type_held_ff, type_held_in;
   logic [15:0]     sequence_held_ff, sequence_held_in;
   logic [15:0]     length_held_ff, length_held_in;

   // Response register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [1:0] status_ff, status_in;
   logic       pvalid_ff, pvalid_in;
   logic [7:0] pbyte_ff, pbyte_in;
   logic [7:0] pindex_ff, pindex_in;

   logic                   req_accept;
   logic [15:0]            crc_updated;
   logic [LIMIT_WIDTH-1:0] length_limit;
   logic [15:0]            length_new;
   logic [8:0]             count_next;

   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;
   assign csr_ready  = 1'b1;

   fpc_crc_step u_crc_step (
      .crc_cur   (crc_running_ff),
      .data_byte (req_in_byte),
      .crc_next  (crc_updated)
   );

   // The effective limit is the smaller of the register and the fixed depth.
   always_comb begin
      if (payload_limit_ff > 9'(PAYLOAD_DEPTH)) begin
         length_limit = LIMIT_WIDTH'(PAYLOAD_DEPTH);
      end else begin
         length_limit = LIMIT_WIDTH'(payload_limit_ff);
      end
   end

   assign length_new = {req_in_byte, length_held_ff[7:0]};
   assign count_next = payload_count_ff + 9'd1;

   // Next-state decode for one byte.
   always_comb begin
      state_in         = state_ff;
      crc_running_in   = crc_running_ff;
      crc_low_in       = crc_low_ff;
      payload_count_in = payload_count_ff;
      type_held_in     = type_held_ff;
      sequence_held_in = sequence_held_ff;
      length_held_in   = length_held_ff;
      status_in        = STATUS_NONE;
      pvalid_in        = 1'b0;
      pbyte_in         = 8'h00;
      pindex_in        = 8'h00;

      unique case (state_ff)
         ST_SOF0: begin
            if (req_in_byte == sof_first_ff) begin
               state_in = ST_SOF1;
            end
         end
         ST_SOF1: begin
            if (req_in_byte == sof_second_ff) begin
               state_in       = ST_VER;
               crc_running_in = CRC_INIT;
            end else if (req_in_byte != sof_first_ff) begin
               state_in = ST_SOF0;
            end
         end
         ST_VER: begin
            if (req_in_byte != frame_version_ff) begin
               state_in         = (req_in_byte == sof_first_ff) ? ST_SOF1 : ST_SOF0;
               payload_count_in = '0;
               crc_running_in   = CRC_INIT;
               crc_low_in       = 8'h00;
               status_in        = STATUS_FORMAT_ERROR;
            end else begin
               crc_running_in = crc_updated;
               state_in       = ST_TYPE;
            end
         end
         ST_TYPE: begin
            type_held_in   = req_in_byte;
            crc_running_in = crc_updated;
            state_in       = ST_SEQL;
         end
         ST_SEQL: begin
            sequence_held_in = {8'h00, req_in_byte};
            crc_running_in   = crc_updated;
            state_in         = ST_SEQH;
         end
         ST_SEQH: begin
            sequence_held_in = {req_in_byte, sequence_held_ff[7:0]};
            crc_running_in   = crc_updated;
            state_in         = ST_LENL;
         end
         ST_LENL: begin
            length_held_in = {8'h00, req_in_byte};
            crc_running_in = crc_updated;
            state_in       = ST_LENH;
         end
         ST_LENH: begin
            length_held_in = length_new;
            if (length_new > 16'(length_limit)) begin
               // Rejected length: this byte may open the next frame.
               state_in         = (req_in_byte == sof_first_ff) ? ST_SOF1 : ST_SOF0;
               payload_count_in = '0;
               crc_running_in   = CRC_INIT;
               crc_low_in       = 8'h00;
               status_in        = STATUS_FORMAT_ERROR;
            end else begin
               crc_running_in   = crc_updated;
               payload_count_in = '0;
               state_in         = (length_new == 16'h0000) ? ST_CRCL : ST_DATA;
            end
         end
         ST_DATA: begin
            pvalid_in        = 1'b1;
            pbyte_in         = req_in_byte;
            pindex_in        = payload_count_ff[7:0];
            payload_count_in = count_next;
            crc_running_in   = crc_updated;
            if (16'(count_next) >= length_held_ff) begin
               state_in = ST_CRCL;
            end
         end
         ST_CRCL: begin
            crc_low_in = req_in_byte;
            state_in   = ST_CRCH;
         end
         ST_CRCH: begin
            status_in        = ({req_in_byte, crc_low_ff} == crc_running_ff) ?
                               STATUS_FRAME_READY : STATUS_CRC_ERROR;
            state_in         = ST_SOF0;
            payload_count_in = '0;
            crc_running_in   = CRC_INIT;
            crc_low_in       = 8'h00;
         end
         default: begin
            state_in         = (req_in_byte == sof_first_ff) ? ST_SOF1 : ST_SOF0;
            payload_count_in = '0;
            crc_running_in   = CRC_INIT;
            crc_low_in       = 8'h00;
            status_in        = STATUS_FORMAT_ERROR;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control state and configuration.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_SOF0;
         crc_running_ff   <= CRC_INIT;
         crc_low_ff       <= 8'h00;
         payload_count_ff <= '0;
         type_held_ff     <= 8'h00;
         sequence_held_ff <= 16'h0000;
         length_held_ff   <= 16'h0000;
         rsp_valid_ff     <= 1'b0;
         sof_first_ff     <= SOF_FIRST_RESET;
         sof_second_ff    <= SOF_SECOND_RESET;
         frame_version_ff <= FRAME_VERSION_RESET;
         payload_limit_ff <= PAYLOAD_LIMIT_RESET;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            state_ff         <= state_in;
            crc_running_ff   <= crc_running_in;
            crc_low_ff       <= crc_low_in;
            payload_count_ff <= payload_count_in;
            type_held_ff     <= type_held_in;
            sequence_held_ff <= sequence_held_in;
            length_held_ff   <= length_held_in;
         end
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_SOF_FIRST:     sof_first_ff     <= csr_data[7:0];
               CSR_SOF_SECOND:    sof_second_ff    <= csr_data[7:0];
               CSR_FRAME_VERSION: frame_version_ff <= csr_data[7:0];
               CSR_PAYLOAD_LIMIT: payload_limit_ff <= csr_data;
               default: begin
               end
            endcase
         end
      end
   end

   // Response payload register.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         status_ff <= status_in;
         pvalid_ff <= pvalid_in;
         pbyte_ff  <= pbyte_in;
         pindex_ff <= pindex_in;
      end
   end

   // The held fields change only when a byte is accepted, which is also when
   // the response register loads, so they always match the shown response.
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_frame_kind     = type_held_ff;
   assign rsp_sequence_res   = sequence_held_ff;
   assign rsp_body_length    = length_held_ff;
   assign rsp_payload_valid  = pvalid_ff;
   assign rsp_payload_byte   = pbyte_ff;
   assign rsp_body_index     = pindex_ff;

endmodule

`default_nettype wire

// File: hdl/fpc_checker.sv
// Port-level checks of the frame parser, bound to its top level.
`default_nettype none

module fpc_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_ready,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [1:0] rsp_status,
   input wire logic       rsp_payload_valid,
   input wire logic [7:0] rsp_payload_byte,
   input wire logic [7:0] rsp_body_index
);
   import fpc_pkg::*;

   // Every accepted byte yields a response in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted byte produced no response");

   // A stalled response keeps its content.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
         $stable(rsp_payload_valid) && $stable(rsp_payload_byte))
      else $error("stalled response changed");

   // A payload byte never carries a frame status.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload_valid |-> rsp_status == STATUS_NONE)
      else $error("payload byte with non-empty status");

   // Non-payload responses carry zero payload fields.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload_valid |->
         rsp_payload_byte == 8'h00 && rsp_body_index == 8'h00)
      else $error("payload fields set on non-payload response");

   // After reset the block is empty and ready for a byte.
   assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("block not empty after reset");

endmodule

bind frame_parser_crc16 fpc_checker u_fpc_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_status        (rsp_status),
   .rsp_payload_valid (rsp_payload_valid),
   .rsp_payload_byte  (rsp_payload_byte),
   .rsp_body_index    (rsp_body_index)
);

`default_nettype wire

// File: verif/tb_frame_parser_crc16.sv
// Self-checking testbench for the byte-serial frame parser with CRC16 check.
`timescale 1ns / 1ps

module tb_frame_parser_crc16;
   import fpc_pkg::*;

   // A generous ceiling on the length of the run.
   localparam int CYCLE_LIMIT = 400000;

   // One response transaction as the parser reports it.
   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  frame_kind;
      logic [15:0] sequence_res;
      logic [15:0] body_length;
      logic        payload_valid;
      logic [7:0]  payload_byte;
      logic [7:0]  body_index;
   } frame_result_type;

   // One configuration write transaction.
   typedef struct packed {
      logic [CSR_INDEX_WIDTH-1:0] reg_idx;
      logic [CSR_DATA_WIDTH-1:0]  value;
   } reg_write_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_in_byte = 8'h00;

   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   logic [7:0]  rsp_frame_kind;
   logic [15:0] rsp_sequence_res;
   logic [15:0] rsp_body_length;
   logic        rsp_payload_valid;
   logic [7:0]  rsp_payload_byte;
   logic [7:0]  rsp_body_index;

   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_data = '0;

   // Stream bytes waiting to be offered, register writes waiting to be offered,
   // and the parse results still owed by the block, oldest first.
   logic [7:0]       rx_bytes_pending[$];
   reg_write_type    reg_writes_pending[$];
   frame_result_type parse_results_due[$];

   // Percentages of cycles in which the sender idles and the receiver stalls.
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;

   int mismatch_count = 0;
   int cycle_count = 0;

   // Our own copy of the configuration registers, starting from their reset values.
   logic [7:0] cfg_sof_first = SOF_FIRST_RESET;
   logic [7:0] cfg_sof_second = SOF_SECOND_RESET;
   logic [7:0] cfg_version = FRAME_VERSION_RESET;
   logic [8:0] cfg_limit = PAYLOAD_LIMIT_RESET;

   // Our own copy of the parser state, again from reset.
   parse_state_type parse_st = ST_SOF0;
   logic [15:0] crc_acc = CRC_INIT;
   logic [15:0] crc_rx = 16'h0000;
   logic [8:0]  body_count = 9'd0;
   logic [7:0]  held_type = 8'h00;
   logic [15:0] held_seq = 16'h0000;
   logic [15:0] held_len = 16'h0000;

   frame_parser_crc16 dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_in_byte        (req_in_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_status         (rsp_status),
      .rsp_frame_kind     (rsp_frame_kind),
      .rsp_sequence_res   (rsp_sequence_res),
      .rsp_body_length    (rsp_body_length),
      .rsp_payload_valid  (rsp_payload_valid),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_body_index     (rsp_body_index),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // One byte through CRC16-CCITT-FALSE, most significant bit first, no reflection.
   function automatic logic [15:0] crc16_next(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int k = 0; k < 8; k++) begin
         c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

   // Abandon the current frame. The offending byte may itself open the next one,
   // so a byte equal to the first start byte leaves us waiting for the second.
   function automatic void restart_search(input logic [7:0] b);
      parse_st = (b == cfg_sof_first) ? ST_SOF1 : ST_SOF0;
      body_count = 9'd0;
      crc_acc = CRC_INIT;
      crc_rx = 16'h0000;
   endfunction

   // Advances our parser copy by one stream byte and returns what the block must report.
   function automatic frame_result_type parse_byte(input logic [7:0] b);
      frame_result_type r;
      logic [8:0] lim;
      r = '0;
      r.status = STATUS_NONE;
      case (parse_st)
         ST_SOF0: begin
            if (b == cfg_sof_first) parse_st = ST_SOF1;
         end
         ST_SOF1: begin
            // A repeated first start byte keeps us waiting for the second one.
            if (b == cfg_sof_second) begin
               parse_st = ST_VER;
               crc_acc = CRC_INIT;
            end else if (b != cfg_sof_first) begin
               parse_st = ST_SOF0;
            end
         end
         ST_VER: begin
            if (b != cfg_version) begin
               restart_search(b);
               r.status = STATUS_FORMAT_ERROR;
            end else begin
               crc_acc = crc16_next(crc_acc, b);
               parse_st = ST_TYPE;
            end
         end
         ST_TYPE: begin
            held_type = b;
            crc_acc = crc16_next(crc_acc, b);
            parse_st = ST_SEQL;
         end
         ST_SEQL: begin
            held_seq = {8'h00, b};
            crc_acc = crc16_next(crc_acc, b);
            parse_st = ST_SEQH;
         end
         ST_SEQH: begin
            held_seq = {b, held_seq[7:0]};
            crc_acc = crc16_next(crc_acc, b);
            parse_st = ST_LENL;
         end
         ST_LENL: begin
            held_len = {8'h00, b};
            crc_acc = crc16_next(crc_acc, b);
            parse_st = ST_LENH;
         end
         ST_LENH: begin
            // The rejected length stays visible; only the framing state is dropped.
            held_len = {b, held_len[7:0]};
            crc_acc = crc16_next(crc_acc, b);
            lim = (cfg_limit > 9'(PAYLOAD_DEPTH)) ? 9'(PAYLOAD_DEPTH) : cfg_limit;
            if (held_len > {7'd0, lim}) begin
               restart_search(b);
               r.status = STATUS_FORMAT_ERROR;
            end else begin
               body_count = 9'd0;
               parse_st = (held_len == 16'd0) ? ST_CRCL : ST_DATA;
            end
         end
         ST_DATA: begin
            r.payload_valid = 1'b1;
            r.payload_byte = b;
            r.body_index = body_count[7:0];
            body_count = body_count + 9'd1;
            crc_acc = crc16_next(crc_acc, b);
            if ({7'd0, body_count} >= held_len) parse_st = ST_CRCL;
         end
         ST_CRCL: begin
            crc_rx = {8'h00, b};
            parse_st = ST_CRCH;
         end
         ST_CRCH: begin
            crc_rx = {b, crc_rx[7:0]};
            r.status = (crc_rx == crc_acc) ? STATUS_FRAME_READY : STATUS_CRC_ERROR;
            parse_st = ST_SOF0;
            body_count = 9'd0;
            crc_acc = CRC_INIT;
            crc_rx = 16'h0000;
         end
         default: begin
            restart_search(b);
            r.status = STATUS_FORMAT_ERROR;
         end
      endcase
      r.frame_kind = held_type;
      r.sequence_res = held_seq;
      r.body_length = held_len;
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [15:0] want,
                                       input logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatch_count++;
      end
   endfunction

   // Byte driver. Each accepted request transaction is run through our parser copy
   // straight away, so the owed results line up with the block's own ordering.
   // A byte once offered is held until it is taken.
   always @(posedge clock) begin : drive_bytes
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            parse_results_due.push_back(parse_byte(req_in_byte));
         end
         if (!req_valid || req_ready) begin
            if (rx_bytes_pending.size() != 0 &&
                $urandom_range(0, 99) >= sender_idle_pct) begin
               req_valid <= 1'b1;
               req_in_byte <= rx_bytes_pending.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Register write driver. Writes are only queued while the parser is quiet,
   // so updating our configuration copy here cannot overtake a byte in flight.
   always @(posedge clock) begin : drive_csr
      if (reset) begin
         csr_valid <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_SOF_FIRST:     cfg_sof_first <= csr_data[7:0];
               CSR_SOF_SECOND:    cfg_sof_second <= csr_data[7:0];
               CSR_FRAME_VERSION: cfg_version <= csr_data[7:0];
               CSR_PAYLOAD_LIMIT: cfg_limit <= csr_data;
               default: ;
            endcase
         end
         if (!csr_valid || csr_ready) begin
            if (reg_writes_pending.size() != 0) begin
               csr_valid <= 1'b1;
               {csr_index, csr_data} <= reg_writes_pending.pop_front();
            end else begin
               csr_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor. Every response transaction is matched against the oldest
   // owed result; the ready line is then redrawn for the next cycle.
   always @(posedge clock) begin : check_results
      frame_result_type due;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (parse_results_due.size() == 0) begin
               $error("response with status %0d while no byte was outstanding", rsp_status);
               mismatch_count++;
            end else begin
               due = parse_results_due.pop_front();
               check_field("status", 16'(due.status), 16'(rsp_status));
               check_field("frame_kind", 16'(due.frame_kind), 16'(rsp_frame_kind));
               check_field("sequence_res", due.sequence_res, rsp_sequence_res);
               check_field("body_length", due.body_length, rsp_body_length);
               check_field("payload_valid", 16'(due.payload_valid), 16'(rsp_payload_valid));
               check_field("payload_byte", 16'(due.payload_byte), 16'(rsp_payload_byte));
               check_field("body_index", 16'(due.body_index), 16'(rsp_body_index));
            end
         end
         rsp_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin : watchdog
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Waits until nothing is queued, nothing is offered and nothing is owed.
   task automatic wait_until_quiet();
      while (rx_bytes_pending.size() != 0 || req_valid || parse_results_due.size() != 0 ||
             reg_writes_pending.size() != 0 || csr_valid) begin
         @(negedge clock);
      end
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [CSR_DATA_WIDTH-1:0] value);
      reg_writes_pending.push_back({idx, value});
   endtask

   // Queues one frame under the current configuration. body_len may fall short of
   // len to give a truncated frame, and spoil_crc corrupts the trailing checksum.
   task automatic add_frame(input logic [7:0] ver, input logic [7:0] kind,
                            input logic [15:0] seq, input logic [15:0] len,
                            input int body_len, input bit spoil_crc);
      logic [47:0] head;
      logic [15:0] crc;
      logic [7:0]  pb;
      head = {len, seq, kind, ver};
      crc = CRC_INIT;
      rx_bytes_pending.push_back(cfg_sof_first);
      rx_bytes_pending.push_back(cfg_sof_second);
      for (int i = 0; i < 6; i++) begin
         crc = crc16_next(crc, head[8*i +: 8]);
         rx_bytes_pending.push_back(head[8*i +: 8]);
      end
      for (int i = 0; i < body_len; i++) begin
         pb = 8'($urandom);
         crc = crc16_next(crc, pb);
         rx_bytes_pending.push_back(pb);
      end
      if (spoil_crc) crc = crc ^ 16'($urandom_range(1, 65535));
      rx_bytes_pending.push_back(crc[7:0]);
      rx_bytes_pending.push_back(crc[15:8]);
   endtask

   // Mostly well-formed frames with random content and short payloads, now and then
   // a payload of the largest accepted size, and the rest broken frames and noise.
   task automatic add_random_traffic(input int n_bytes);
      int target;
      int eff;
      int len;
      int pick;
      target = rx_bytes_pending.size() + n_bytes;
      eff = (int'(cfg_limit) > int'(PAYLOAD_DEPTH)) ? int'(PAYLOAD_DEPTH) : int'(cfg_limit);
      while (rx_bytes_pending.size() < target) begin
         pick = $urandom_range(0, 99);
         len = ($urandom_range(0, 9) == 0) ? eff : $urandom_range(0, (eff < 12) ? eff : 12);
         if (pick < 72) begin
            add_frame(cfg_version, 8'($urandom), 16'($urandom), 16'(len), len,
                      $urandom_range(0, 9) == 0);
         end else if (pick < 80) begin
            add_frame(cfg_version ^ 8'($urandom_range(1, 255)), 8'($urandom),
                      16'($urandom), 16'(len), len, 1'b0);
         end else if (pick < 88) begin
            len = $urandom_range(eff + 1, 65535);
            add_frame(cfg_version, 8'($urandom), 16'($urandom), 16'(len), 0, 1'b0);
         end else if (pick < 94) begin
            add_frame(cfg_version, 8'($urandom), 16'($urandom), 16'(len),
                      $urandom_range(0, len), 1'b0);
         end else begin
            repeat ($urandom_range(1, 6)) rx_bytes_pending.push_back(8'($urandom));
         end
      end
   endtask

   initial begin : stimulus
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset configuration, both sides always ready.
      // A doubled first start byte ahead of a zero-length frame with the
      // largest type and sequence values; it must end in frame ready.
      rx_bytes_pending.push_back(cfg_sof_first);
      add_frame(cfg_version, 8'hFF, 16'hFFFF, 16'h0000, 0, 1'b0);
      // A bad version byte that equals the first start byte reopens the search,
      // and the following start byte and zero version give a second format error.
      rx_bytes_pending.push_back(cfg_sof_first);
      rx_bytes_pending.push_back(cfg_sof_second);
      rx_bytes_pending.push_back(cfg_sof_first);
      rx_bytes_pending.push_back(cfg_sof_second);
      rx_bytes_pending.push_back(8'h00);
      // A length over the limit whose high byte is the first start byte.
      add_frame(cfg_version, 8'h00, 16'h0000, {cfg_sof_first, 8'h00}, 0, 1'b0);
      add_random_traffic(240);
      wait_until_quiet();

      // Lowest limit, so only empty payloads pass; the sender idles heavily.
      write_reg(CSR_SOF_FIRST, 9'h000);
      write_reg(CSR_SOF_SECOND, 9'h0FF);
      write_reg(CSR_FRAME_VERSION, 9'h0FF);
      write_reg(CSR_PAYLOAD_LIMIT, 9'h000);
      wait_until_quiet();
      sender_idle_pct = 70;
      add_random_traffic(240);
      wait_until_quiet();

      // Identical start bytes and a limit above the payload depth; the receiver stalls.
      write_reg(CSR_SOF_FIRST, 9'h0FF);
      write_reg(CSR_SOF_SECOND, 9'h0FF);
      write_reg(CSR_FRAME_VERSION, 9'h000);
      write_reg(CSR_PAYLOAD_LIMIT, 9'h1FF);
      wait_until_quiet();
      sender_idle_pct = 0;
      receiver_stall_pct = 70;
      add_random_traffic(240);
      wait_until_quiet();

      // Random framing bytes and a small limit, with both sides pausing.
      write_reg(CSR_SOF_FIRST, 9'($urandom_range(0, 255)));
      write_reg(CSR_SOF_SECOND, 9'($urandom_range(0, 255)));
      write_reg(CSR_FRAME_VERSION, 9'($urandom_range(0, 255)));
      write_reg(CSR_PAYLOAD_LIMIT, 9'($urandom_range(1, 16)));
      wait_until_quiet();
      sender_idle_pct = 35;
      receiver_stall_pct = 35;
      add_random_traffic(240);
      wait_until_quiet();

      // Writes to unknown indexes must be ignored, and the ninth data bit must be
      // dropped by the byte-wide registers on the way back to the defaults.
      write_reg(8'($urandom_range(4, 254)), 9'($urandom));
      write_reg(8'hFF, 9'h1FF);
      write_reg(CSR_SOF_FIRST, {1'b1, SOF_FIRST_RESET});
      write_reg(CSR_SOF_SECOND, {1'b1, SOF_SECOND_RESET});
      write_reg(CSR_FRAME_VERSION, {1'b1, FRAME_VERSION_RESET});
      write_reg(CSR_PAYLOAD_LIMIT, PAYLOAD_LIMIT_RESET);
      wait_until_quiet();
      add_random_traffic(240);
      wait_until_quiet();

      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
